// ===== rtl/fmts_pkg.sv =====
`timescale 1ns / 1ps

package fmts_pkg;

    localparam int NUM_CH  = 9;
    localparam int NUM_OPS = 2 * NUM_CH;
    localparam int OPW     = $clog2(NUM_OPS);
    localparam int CHW     = $clog2(NUM_CH);

    typedef logic [OPW-1:0] op_idx_t;

    localparam logic [1:0] OP_LATCH = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] STEP_ENV = 2'd0;
    localparam logic [1:0] STEP_ATT = 2'd1;
    localparam logic [1:0] STEP_LOG = 2'd2;
    localparam logic [1:0] STEP_EXP = 2'd3;

    localparam logic [2:0] EG_IDLE    = 3'd0;
    localparam logic [2:0] EG_ATTACK  = 3'd1;
    localparam logic [2:0] EG_DECAY   = 3'd2;
    localparam logic [2:0] EG_SUSTAIN = 3'd3;
    localparam logic [2:0] EG_RELEASE = 3'd4;

    localparam logic [7:0] ADDR_RHYTHM = 8'h0E;
    localparam logic [7:0] ADDR_USER_END = 8'h08;
    localparam logic [7:0] ADDR_LIMIT  = 8'h40;
    localparam logic [3:0] GRP_FNUM_LO = 4'h1;
    localparam logic [3:0] GRP_FNUM_HI = 4'h2;
    localparam logic [3:0] GRP_INST    = 4'h3;

    localparam logic [63:0] DRUM_BD = 64'h6D_6A_F8_DF_0F_18_01_01;
    localparam logic [63:0] DRUM_HS = 64'h68_A7_D8_C8_00_00_01_01;
    localparam logic [63:0] DRUM_TC = 64'h55_59_AA_F8_00_00_01_05;

    typedef struct packed {
        logic    latch;
        logic    write;
        logic    start;
        logic    step_en;
        logic [1:0] step;
        op_idx_t op;
        logic    finish;
    } cmd_t;

    typedef logic [11:0] lsin_tbl_t [256];
    typedef logic [9:0]  exp_tbl_t [256];

    function automatic logic [63:0] log2_frac(input logic [63:0] m_in);
        logic [63:0] m;
        logic [63:0] f;
        m = m_in;
        f = '0;
        for (int k = 1; k <= 30; k++)
        begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000)
            begin
                m = m >> 1;
                f = f | (64'd1 << (30 - k));
            end
        end
        return f;
    endfunction

    function automatic logic [63:0] series_div(input int n, input logic [63:0] t);
        case (n)
            1: return t / 64'd6;
            2: return t / 64'd20;
            3: return t / 64'd42;
            4: return t / 64'd72;
            5: return t / 64'd110;
            6: return t / 64'd156;
            7: return t / 64'd210;
            8: return t / 64'd272;
            default: return t / 64'd342;
        endcase
    endfunction

    function automatic lsin_tbl_t build_log_sine();
        lsin_tbl_t tbl;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] e;
        logic [63:0] f;
        logic signed [63:0] acc;
        for (int i = 0; i < 256; i++)
        begin
            x = ((64'(2 * i + 1)) * 64'd3373259426 + 64'd512) >> 10;
            term = x;
            acc = $signed(x);
            for (int n = 1; n <= 9; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = series_div(n, term);
                if ((n & 1) == 1)
                    acc = acc - $signed(term);
                else
                    acc = acc + $signed(term);
            end
            s = (acc > 64'sd0) ? $unsigned(acc) : 64'd1;
            e = '0;
            for (int j = 0; j < 40; j++)
            begin
                if (s < 64'h4000_0000)
                begin
                    s = s << 1;
                    e = e + 64'd1;
                end
            end
            f = log2_frac(s);
            tbl[i] = 12'(((e << 30) - f + 64'd2097152) >> 22);
        end
        return tbl;
    endfunction

    function automatic exp_tbl_t build_exp();
        exp_tbl_t tbl;
        logic [63:0] k;
        k = '0;
        for (int i = 0; i < 256; i++)
        begin
            while (k < 64'd1023 &&
                   log2_frac((64'd2047 + 64'd2 * (k + 64'd1)) << 19) <= (64'(i) << 22))
                k = k + 64'd1;
            tbl[i] = k[9:0];
        end
        return tbl;
    endfunction

    localparam lsin_tbl_t LOG_SINE = build_log_sine();
    localparam exp_tbl_t  EXP_TBL  = build_exp();

    function automatic logic [4:0] mult_x2(input logic [3:0] m);
        case (m)
            4'd0:  return 5'd1;
            4'd1:  return 5'd2;
            4'd2:  return 5'd4;
            4'd3:  return 5'd6;
            4'd4:  return 5'd8;
            4'd5:  return 5'd10;
            4'd6:  return 5'd12;
            4'd7:  return 5'd14;
            4'd8:  return 5'd16;
            4'd9:  return 5'd18;
            4'd10: return 5'd20;
            4'd11: return 5'd20;
            4'd12: return 5'd24;
            4'd13: return 5'd24;
            default: return 5'd30;
        endcase
    endfunction

    function automatic logic [5:0] ksl_base(input logic [3:0] i);
        case (i)
            4'd0:  return 6'd0;
            4'd1:  return 6'd24;
            4'd2:  return 6'd32;
            4'd3:  return 6'd37;
            4'd4:  return 6'd40;
            4'd5:  return 6'd43;
            4'd6:  return 6'd45;
            4'd7:  return 6'd47;
            4'd8:  return 6'd48;
            4'd9:  return 6'd50;
            4'd10: return 6'd51;
            4'd11: return 6'd52;
            4'd12: return 6'd53;
            4'd13: return 6'd54;
            4'd14: return 6'd55;
            default: return 6'd56;
        endcase
    endfunction

    function automatic logic [1:0] eg_inc(input logic [1:0] row, input logic [2:0] col);
        case (row)
            2'd0: return 2'd1;
            2'd1: return (col[1:0] == 2'd3) ? 2'd2 : 2'd1;
            2'd2: return col[0] ? 2'd2 : 2'd1;
            default: return (col[1:0] == 2'd0) ? 2'd1 : 2'd2;
        endcase
    endfunction

    function automatic logic [63:0] rom_patch(input logic [3:0] i);
        case (i)
            4'd0:  return 64'h17_00_78_D0_17_1E_61_71;
            4'd1:  return 64'h13_23_F7_D8_0D_1A_41_13;
            4'd2:  return 64'h23_21_C4_F2_00_99_01_13;
            4'd3:  return 64'h27_70_64_8D_07_0E_61_11;
            4'd4:  return 64'h28_01_76_E1_06_1E_21_32;
            4'd5:  return 64'h18_00_71_E0_05_16_22_31;
            4'd6:  return 64'h07_11_81_82_07_1D_61_21;
            4'd7:  return 64'h07_00_70_B0_13_2D_21_33;
            4'd8:  return 64'h17_10_65_64_06_1B_61_61;
            4'd9:  return 64'h07_81_F0_85_18_0B_61_41;
            4'd10: return 64'h04_10_EF_EA_11_83_01_33;
            4'd11: return 64'h12_22_F8_F8_07_24_C1_17;
            4'd12: return 64'h42_40_F5_D2_05_0C_50_61;
            4'd13: return 64'h02_03_90_E9_03_55_01_01;
            default: return 64'h13_C0_E4_F1_03_89_41_41;
        endcase
    endfunction

endpackage

// ===== rtl/fmts_ctrl.sv =====
`timescale 1ns / 1ps

module fmts_ctrl
    import fmts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [1:0] op,
    output logic       sample_valid,
    input  logic       sample_ready,
    output cmd_t       cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    op_idx_t    op_reg, op_next;
    logic [1:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    logic       accept;
    logic       finish;

    assign item_ready   = (state_reg == S_IDLE);
    assign sample_valid = valid_reg;
    assign accept       = item_valid && item_ready;
    assign finish       = (state_reg == S_DONE) && (!valid_reg || sample_ready);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        step_next  = step_reg;
        valid_next = valid_reg;
        if (valid_reg && sample_ready)
            valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && op == OP_TICK)
                begin
                    state_next = S_RUN;
                    op_next    = '0;
                    step_next  = STEP_ENV;
                end
            end
            S_RUN:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == STEP_EXP)
                begin
                    if (op_reg == op_idx_t'(NUM_OPS - 1))
                        state_next = S_DONE;
                    else
                        op_next = op_reg + op_idx_t'(1);
                end
            end
            S_DONE:
            begin
                if (finish)
                begin
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.latch   = accept && op == OP_LATCH;
        cmd.write   = accept && op == OP_WRITE;
        cmd.start   = accept && op == OP_TICK;
        cmd.step_en = (state_reg == S_RUN);
        cmd.step    = step_reg;
        cmd.op      = op_reg;
        cmd.finish  = finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
            step_reg  <= STEP_ENV;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== rtl/fmts_dp.sv =====
`timescale 1ns / 1ps

module fmts_dp
    import fmts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic [7:0]          value,
    output logic signed [15:0]  sample
);

    logic [7:0]  addr_reg;
    logic [7:0]  r0e_reg;
    logic [7:0]  upatch_reg [8];
    logic [8:0]  fnum_reg [NUM_CH];
    logic [2:0]  block_reg [NUM_CH];
    logic [NUM_CH-1:0] key_reg;
    logic [NUM_CH-1:0] sus_reg;
    logic [7:0]  instvol_reg [NUM_CH];
    logic [18:0] phase_reg [NUM_OPS];
    logic [6:0]  level_reg [NUM_OPS];
    logic [2:0]  stage_reg [NUM_OPS];
    logic signed [12:0] hist0_reg [NUM_CH];
    logic signed [12:0] hist1_reg [NUM_CH];
    logic [31:0] lfo_reg;
    logic [22:0] noise_reg;
    logic [8:0]  trem_reg;
    logic signed [17:0] acc_reg;
    logic [15:0] sample_reg;
    logic        pair_act_reg;
    logic        act_reg;
    logic signed [12:0] fm_reg;
    logic [13:0] att_reg;
    logic [7:0]  q_reg;
    logic        neg_reg;
    logic        zero_reg;
    logic        sine_reg;
    logic [13:0] lvl_reg;

    op_idx_t         o;
    logic [CHW-1:0]  c;
    logic            slot;
    logic            rhythm;
    logic            single;
    logic [63:0]     p;
    logic [7:0]      flags, a1, a2, b2, b3;
    logic [8:0]      fn;
    logic [2:0]      blk;
    logic [NUM_CH-1:0] chan_nz;

    logic [2:0]  cur_stage;
    logic [6:0]  cur_level;
    logic [3:0]  rate;
    logic [4:0]  ksr;
    logic [6:0]  eff_raw;
    logic [5:0]  eff;
    logic [3:0]  sa;
    logic        masked;
    logic [18:0] lfo_sh;
    logic [1:0]  inc;
    logic        env_go;
    logic [5:0]  sub;
    logic signed [8:0] lev;
    logic [2:0]  stage_new;
    logic        act_now;

    logic [11:0] pm;
    logic [12:0] pm_up;
    logic [3:0]  dd;
    logic        wneg;
    logic [9:0]  fnv;
    logic [14:0] prod;
    logic [21:0] stepw;
    logic [18:0] phase_new;

    logic [6:0]  lv;
    logic [18:0] ph;
    logic [1:0]  ksl;
    logic signed [7:0] base;
    logic [8:0]  kadd;
    logic [8:0]  tv;
    logic [5:0]  tadd;
    logic [10:0] tl;
    logic [13:0] att_two;
    logic [13:0] att_single;
    logic [2:0]  fb;
    logic signed [13:0] hs;
    logic signed [13:0] fbv;
    logic [9:0]  fm_sel;
    logic [9:0]  idx;
    logic        dbit;

    logic [11:0] mag;
    logic signed [12:0] val;

    logic [NUM_OPS-1:0] keyon;
    logic [NUM_OPS-1:0] keyoff;
    logic        in_file;
    logic [3:0]  grp;
    logic [3:0]  sub_a;
    logic        env_we;

    assign o      = cmd.op;
    assign c      = o[OPW-1:1];
    assign slot   = o[0];
    assign rhythm = r0e_reg[5];
    assign single = rhythm && (o >= op_idx_t'(14));
    assign sample = sample_reg;

    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
            chan_nz[k] = (stage_reg[2*k] != EG_IDLE) || (stage_reg[2*k+1] != EG_IDLE);
    end

    // patch and channel fields
    always_comb
    begin
        if (rhythm && c == CHW'(6))
            p = DRUM_BD;
        else if (rhythm && c == CHW'(7))
            p = DRUM_HS;
        else if (rhythm && c == CHW'(8))
            p = DRUM_TC;
        else if (instvol_reg[c][7:4] == 4'd0)
            p = {upatch_reg[7], upatch_reg[6], upatch_reg[5], upatch_reg[4],
                 upatch_reg[3], upatch_reg[2], upatch_reg[1], upatch_reg[0]};
        else
            p = rom_patch(instvol_reg[c][7:4] - 4'd1);
        flags = slot ? p[15:8] : p[7:0];
        a1    = slot ? p[47:40] : p[39:32];
        a2    = slot ? p[63:56] : p[55:48];
        b2    = p[23:16];
        b3    = p[31:24];
        fn    = fnum_reg[c];
        blk   = block_reg[c];
    end

    // envelope and phase update
    always_comb
    begin
        cur_stage = stage_reg[o];
        cur_level = level_reg[o];
        case (cur_stage)
            EG_ATTACK:  rate = a1[7:4];
            EG_DECAY:   rate = a1[3:0];
            EG_SUSTAIN: rate = flags[5] ? 4'd0 : a2[3:0];
            EG_RELEASE: rate = sus_reg[c] ? 4'd5 : (flags[5] ? a2[3:0] : 4'd7);
            default:    rate = 4'd0;
        endcase
        ksr = flags[4] ? ({1'b0, blk, 1'b0} + {4'b0, fn[8]}) : {3'b0, blk[2:1]};
        eff_raw = {1'b0, rate, 2'b00} + {2'b0, ksr};
        eff = (eff_raw > 7'd63) ? 6'd63 : eff_raw[5:0];
        sa = (eff[5:2] < 4'd12) ? (4'd12 - eff[5:2]) : 4'd0;
        masked = 1'b0;
        for (int k = 0; k < 11; k++)
        begin
            if (4'(k) < sa && lfo_reg[k])
                masked = 1'b1;
        end
        lfo_sh = lfo_reg[18:0] >> sa;
        inc = eg_inc(eff[1:0], lfo_sh[2:0]);
        env_go = (cur_stage != EG_IDLE) && (rate != 4'd0) && !masked;
        sub = {2'b0, cur_level[6:3]} + 6'd1;
        if (inc == 2'd2)
            sub = {sub[4:0], 1'b0};
        lev = $signed({2'b0, cur_level});
        stage_new = cur_stage;
        if (env_go)
        begin
            if (cur_stage == EG_ATTACK)
            begin
                if (eff >= 6'd60)
                    lev = 9'sd0;
                else
                    lev = $signed({2'b0, cur_level}) - $signed({3'b0, sub});
                if (lev <= 9'sd0)
                begin
                    lev = 9'sd0;
                    stage_new = EG_DECAY;
                end
            end
            else
            begin
                lev = $signed({2'b0, cur_level}) + $signed({7'b0, inc});
                if (cur_stage == EG_DECAY && lev >= $signed({2'b0, a2[7:4], 3'b0}))
                    stage_new = EG_SUSTAIN;
                if (lev >= 9'sd127)
                begin
                    lev = 9'sd127;
                    stage_new = EG_IDLE;
                end
            end
        end

        wneg = lfo_reg[12];
        case (lfo_reg[11:10])
            2'd1, 2'd3: pm = {2'b0, fn, 1'b0} + {3'b0, fn};
            2'd2:       pm = {fn, 3'b0} - {3'b0, fn};
            default:    pm = 12'd0;
        endcase
        pm_up = {1'b0, pm} + 13'd511;
        dd = wneg ? pm_up[12:9] : {1'b0, pm[11:9]};
        if (!flags[6])
            fnv = {1'b0, fn};
        else if (wneg)
            fnv = {1'b0, fn} - {6'b0, dd};
        else
            fnv = {1'b0, fn} + {6'b0, dd};
        prod = {5'b0, fnv} * {10'b0, mult_x2(flags[3:0])};
        stepw = {7'b0, prod} << blk;
        phase_new = phase_reg[o] + stepw[19:1];

        if (single)
            act_now = (cur_stage != EG_IDLE);
        else if (!slot)
            act_now = chan_nz[c];
        else
            act_now = pair_act_reg;
        env_we = cmd.step_en && cmd.step == STEP_ENV && act_now;
    end

    // attenuation and table index
    always_comb
    begin
        lv = level_reg[o];
        ph = phase_reg[o];
        ksl = slot ? b3[7:6] : b2[7:6];
        base = $signed({2'b0, ksl_base(fn[8:5])}) - $signed({1'b0, 3'd7 - blk, 3'b0});
        kadd = ({base[5:0], 3'b0}) >> (2'd3 - ksl);
        if (ksl == 2'd0 || base <= 8'sd0)
            kadd = 9'd0;
        tv = (trem_reg < 9'd210) ? trem_reg : (9'd420 - trem_reg);
        tadd = flags[7] ? tv[7:2] : 6'd0;
        tl = slot ? {instvol_reg[c][3:0], 7'b0} : {b2[5:0], 5'b0};
        att_two = {3'b0, lv, 4'b0} + {3'b0, tl} + {5'b0, kadd} + {8'b0, tadd};
        att_single = {3'b0, lv, 4'b0}
                   + {3'b0, (slot ? instvol_reg[c][3:0] : instvol_reg[c][7:4]), 7'b0};
        fb = b3[2:0];
        hs = $signed({hist0_reg[c][12], hist0_reg[c]}) + $signed({hist1_reg[c][12], hist1_reg[c]});
        fbv = hs >>> (4'd9 - {1'b0, fb});
        if (slot)
            fm_sel = fm_reg[9:0];
        else if (fb != 3'd0)
            fm_sel = fbv[9:0];
        else
            fm_sel = 10'd0;
        idx = single ? ph[18:9] : (ph[18:9] + fm_sel);
        if (o == op_idx_t'(14))
            dbit = noise_reg[0];
        else if (o == op_idx_t'(15))
            dbit = ph[18] ^ noise_reg[0];
        else
            dbit = phase_reg[14][17] ^ ph[18];
    end

    // exponential lookup
    always_comb
    begin
        mag = {1'b1, EXP_TBL[~lvl_reg[7:0]], 1'b0} >> lvl_reg[12:8];
        if (lvl_reg > 14'h1FFF)
            mag = 12'd0;
        if (zero_reg)
            val = 13'sd0;
        else if (neg_reg)
            val = -$signed({1'b0, mag});
        else
            val = $signed({1'b0, mag});
    end

    // key on / key off from data writes
    always_comb
    begin
        keyon   = '0;
        keyoff  = '0;
        in_file = addr_reg < ADDR_LIMIT;
        grp     = addr_reg[7:4];
        sub_a   = addr_reg[3:0];
        if (cmd.write && in_file)
        begin
            if (addr_reg == ADDR_RHYTHM)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    if ((value[5] && value[4-i]) && !(r0e_reg[5] && r0e_reg[4-i]))
                    begin
                        case (i)
                            0: keyon[13:12] = 2'b11;
                            1: keyon[15] = 1'b1;
                            2: keyon[16] = 1'b1;
                            3: keyon[17] = 1'b1;
                            default: keyon[14] = 1'b1;
                        endcase
                    end
                    else if (!(value[5] && value[4-i]) && (r0e_reg[5] && r0e_reg[4-i]))
                    begin
                        case (i)
                            0: keyoff[13:12] = 2'b11;
                            1: keyoff[15] = 1'b1;
                            2: keyoff[16] = 1'b1;
                            3: keyoff[17] = 1'b1;
                            default: keyoff[14] = 1'b1;
                        endcase
                    end
                end
            end
            else if (grp == GRP_FNUM_HI && sub_a < 4'(NUM_CH))
            begin
                for (int k = 0; k < NUM_CH; k++)
                begin
                    if (sub_a == 4'(k))
                    begin
                        keyon[2*k]    = value[4] && !key_reg[k];
                        keyon[2*k+1]  = value[4] && !key_reg[k];
                        keyoff[2*k]   = !value[4] && key_reg[k];
                        keyoff[2*k+1] = !value[4] && key_reg[k];
                    end
                end
            end
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            r0e_reg  <= '0;
            key_reg  <= '0;
            sus_reg  <= '0;
            for (int k = 0; k < 8; k++)
                upatch_reg[k] <= '0;
            for (int k = 0; k < NUM_CH; k++)
            begin
                fnum_reg[k]    <= '0;
                block_reg[k]   <= '0;
                instvol_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.latch)
                addr_reg <= value;
            if (cmd.write && in_file)
            begin
                if (addr_reg < ADDR_USER_END)
                    upatch_reg[addr_reg[2:0]] <= value;
                if (addr_reg == ADDR_RHYTHM)
                    r0e_reg <= value;
                for (int k = 0; k < NUM_CH; k++)
                begin
                    if (sub_a == 4'(k))
                    begin
                        if (grp == GRP_FNUM_LO)
                            fnum_reg[k][7:0] <= value;
                        if (grp == GRP_FNUM_HI)
                        begin
                            fnum_reg[k][8] <= value[0];
                            block_reg[k]   <= value[3:1];
                            key_reg[k]     <= value[4];
                            sus_reg[k]     <= value[5];
                        end
                        if (grp == GRP_INST)
                            instvol_reg[k] <= value;
                    end
                end
            end
        end
    end

    // operator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_OPS; k++)
            begin
                phase_reg[k] <= '0;
                level_reg[k] <= '0;
                stage_reg[k] <= EG_IDLE;
            end
        end
        else
        begin
            for (int k = 0; k < NUM_OPS; k++)
            begin
                if (keyon[k])
                begin
                    phase_reg[k] <= '0;
                    level_reg[k] <= 7'd127;
                    stage_reg[k] <= EG_ATTACK;
                end
                else if (keyoff[k])
                begin
                    if (stage_reg[k] != EG_IDLE)
                        stage_reg[k] <= EG_RELEASE;
                end
                else if (env_we && o == op_idx_t'(k))
                begin
                    phase_reg[k] <= phase_new;
                    level_reg[k] <= lev[6:0];
                    stage_reg[k] <= stage_new;
                end
            end
        end
    end

    // operator pipeline, mixing and per-tick state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfo_reg      <= '0;
            noise_reg    <= 23'd1;
            trem_reg     <= '0;
            acc_reg      <= '0;
            sample_reg   <= '0;
            pair_act_reg <= 1'b0;
            act_reg      <= 1'b0;
            fm_reg       <= '0;
            att_reg      <= '0;
            q_reg        <= '0;
            neg_reg      <= 1'b0;
            zero_reg     <= 1'b0;
            sine_reg     <= 1'b0;
            lvl_reg      <= '0;
            for (int k = 0; k < NUM_CH; k++)
            begin
                hist0_reg[k] <= '0;
                hist1_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.start)
                acc_reg <= '0;
            if (cmd.step_en)
            begin
                case (cmd.step)
                    STEP_ENV:
                    begin
                        act_reg <= act_now;
                        if (!slot)
                            pair_act_reg <= act_now;
                    end
                    STEP_ATT:
                    begin
                        att_reg <= single ? att_single : att_two;
                        q_reg   <= idx[8] ? ~idx[7:0] : idx[7:0];
                        if (single && o != op_idx_t'(16))
                        begin
                            sine_reg <= 1'b0;
                            neg_reg  <= !dbit;
                            zero_reg <= 1'b0;
                        end
                        else
                        begin
                            sine_reg <= 1'b1;
                            neg_reg  <= idx[9];
                            zero_reg <= idx[9] && !single && (slot ? b3[4] : b3[3]);
                        end
                    end
                    STEP_LOG:
                    begin
                        lvl_reg <= att_reg + (sine_reg ? {2'b0, LOG_SINE[q_reg]} : 14'd0);
                    end
                    STEP_EXP:
                    begin
                        if (act_reg)
                        begin
                            if (!single && !slot)
                            begin
                                hist1_reg[c] <= hist0_reg[c];
                                hist0_reg[c] <= val;
                                fm_reg       <= val >>> 1;
                            end
                            else
                                acc_reg <= acc_reg + 18'(val);
                        end
                    end
                    default: act_reg <= act_reg;
                endcase
            end
            if (cmd.finish)
            begin
                lfo_reg <= lfo_reg + 32'd1;
                if (lfo_reg[5:0] == 6'h3F)
                begin
                    if (lfo_reg == 32'hFFFF_FFFF || trem_reg == 9'd419)
                        trem_reg <= '0;
                    else
                        trem_reg <= trem_reg + 9'd1;
                end
                if (rhythm)
                    noise_reg <= {noise_reg[0] ^ noise_reg[14], noise_reg[22:1]};
                sample_reg <= acc_reg[16:1];
            end
        end
    end

endmodule

// ===== rtl/fm_two_operator_synth_top.sv =====
// A sample tick runs 18 operators, four steps each, through one shared
// envelope/phase/log-sine/exp unit, then loads the mix into the output once the
// previous sample has been taken. The next tick is taken once the mix is loaded.
// Reset (rst_n low, asynchronous) clears all registers, envelopes, phases and LFO;
// the noise register starts at one.
`timescale 1ns / 1ps

module fm_two_operator_synth_top
    import fmts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         op,
    input  logic [7:0]         value,
    output logic               sample_valid,
    input  logic               sample_ready,
    output logic signed [15:0] sample
);

    cmd_t cmd;

    fmts_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .op           (op),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .cmd          (cmd)
    );

    fmts_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .value  (value),
        .sample (sample)
    );

endmodule
